/* rtl/npc_pkg.sv */
package npc_pkg;

    localparam int unsigned COLOR_W = 8;
    localparam int unsigned IDX_W   = 7;
    localparam int unsigned TAG_W   = 4;
    localparam int unsigned DIST_W  = 18;
    localparam int unsigned SQ_W    = 2 * COLOR_W;

    // Distance reported when no entry was scanned: one more than the largest real one.
    localparam logic [DIST_W-1:0] NO_MATCH_DIST = DIST_W'(3 * 255 * 255 + 1);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    // Marks a palette entry moving through the distance pipeline.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
    } pipe_tag_t;

endpackage

/* rtl/npc_ram.sv */
module npc_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/npc_dist.sv */
module npc_dist (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  npc_pkg::pipe_tag_t            in_tag,
    input  npc_pkg::rgb_t                 entry,
    input  npc_pkg::rgb_t                 color,
    output npc_pkg::pipe_tag_t            out_tag,
    output logic [npc_pkg::DIST_W-1:0]    out_dist
);

    logic [npc_pkg::COLOR_W-1:0] diff_r, diff_g, diff_b;
    logic [npc_pkg::SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    npc_pkg::pipe_tag_t          tag1_reg;
    npc_pkg::pipe_tag_t          tag2_reg;
    logic [npc_pkg::DIST_W-1:0]  dist_reg;
    logic [npc_pkg::DIST_W-1:0]  dist_next;

    always_comb begin
        diff_r = (color.red >= entry.red) ? color.red - entry.red : entry.red - color.red;
        diff_g = (color.green >= entry.green) ? color.green - entry.green
                                              : entry.green - color.green;
        diff_b = (color.blue >= entry.blue) ? color.blue - entry.blue
                                            : entry.blue - color.blue;
        dist_next = npc_pkg::DIST_W'(sq_r_reg) + npc_pkg::DIST_W'(sq_g_reg)
                  + npc_pkg::DIST_W'(sq_b_reg);
    end

    // Stage one squares the three differences, stage two adds them.
    always_ff @(posedge aclk) begin
        sq_r_reg <= diff_r * diff_r;
        sq_g_reg <= diff_g * diff_g;
        sq_b_reg <= diff_b * diff_b;
        dist_reg <= dist_next;
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
        end
    end

    assign out_tag  = tag2_reg;
    assign out_dist = dist_reg;

endmodule

/* rtl/nearest_palette_color.sv */
// Write words are taken one per cycle while no query is in progress, and give no result.
// A query scans the first N = min(entries_in_use, PALETTE_DEPTH) entries, one RAM read a
// cycle into a shared two-stage distance unit. m_tvalid rises and s_tready returns in the
// same cycle, when the result is loaded into the free output register.
// Reset (aresetn low, synchronous) clears the sequencer, the output valid and entries_in_use;
// the palette RAM is not cleared and holds nothing defined until written.
module nearest_palette_color #(
    parameter int unsigned PALETTE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[6:0], red[14:7], green[22:15], blue[30:23], query_tag[34:31], zeros
    input  logic [39:0] s_tdata,
    // func[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tag_out[3:0], best_index[10:4], best_distance[28:11], zeros
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    localparam int unsigned AW = $clog2(PALETTE_DEPTH);
    localparam logic [8:0]  DEPTH_9 = 9'(PALETTE_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [npc_pkg::IDX_W-1:0]  cfg_count_reg;
    logic [npc_pkg::IDX_W-1:0]  count_reg;
    logic [npc_pkg::IDX_W-1:0]  issue_idx_reg;
    npc_pkg::pipe_tag_t         issue_tag_reg;
    npc_pkg::rgb_t              color_reg;
    logic [npc_pkg::TAG_W-1:0]  qtag_reg;
    logic [npc_pkg::DIST_W-1:0] best_dist_reg;
    logic [npc_pkg::IDX_W-1:0]  best_idx_reg;
    logic                       m_tvalid_reg;
    logic [31:0]                m_tdata_reg;

    logic                       in_func;
    logic [npc_pkg::IDX_W-1:0]  in_index;
    npc_pkg::rgb_t              in_color;
    logic [npc_pkg::TAG_W-1:0]  in_tag;
    logic                       accept;
    logic                       wr_en;
    logic [npc_pkg::IDX_W-1:0]  wr_idx_m1;
    logic [npc_pkg::IDX_W-1:0]  rd_idx_m1;
    logic [npc_pkg::IDX_W-1:0]  count_sat;
    logic                       rd_en;
    logic [23:0]                rd_data;
    npc_pkg::pipe_tag_t         dist_tag;
    logic [npc_pkg::DIST_W-1:0] dist_val;
    logic                       out_free;

    assign in_func        = s_tuser[0];
    assign in_index       = s_tdata[6:0];
    assign in_color.red   = s_tdata[14:7];
    assign in_color.green = s_tdata[22:15];
    assign in_color.blue  = s_tdata[30:23];
    assign in_tag         = s_tdata[34:31];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Writes outside entries one through the depth are dropped.
    assign wr_en = accept && (in_func == npc_pkg::FUNC_WRITE) && (in_index != '0)
                   && ({2'b00, in_index} <= DEPTH_9);
    assign wr_idx_m1 = in_index - 7'd1;
    assign rd_idx_m1 = issue_idx_reg - 7'd1;
    assign rd_en     = (state_reg == ST_SCAN);

    assign count_sat = ({2'b00, cfg_count_reg} > DEPTH_9) ? DEPTH_9[6:0] : cfg_count_reg;

    npc_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (AW'(wr_idx_m1)),
        .wdata (in_color),
        .re    (rd_en),
        .raddr (AW'(rd_idx_m1)),
        .rdata (rd_data)
    );

    npc_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (issue_tag_reg),
        .entry    (npc_pkg::rgb_t'(rd_data)),
        .color    (color_reg),
        .out_tag  (dist_tag),
        .out_dist (dist_val)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (in_func == npc_pkg::FUNC_QUERY)) begin
                    state_next = (count_sat == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue_idx_reg == count_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (dist_tag.valid && (dist_tag.index == count_reg)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_count_reg <= '0;
            issue_tag_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                cfg_count_reg <= cfg_data;
            end
            issue_tag_reg.valid <= rd_en;
            issue_tag_reg.index <= issue_idx_reg;
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end

        if (accept && (in_func == npc_pkg::FUNC_QUERY)) begin
            color_reg     <= in_color;
            qtag_reg      <= in_tag;
            count_reg     <= count_sat;
            issue_idx_reg <= 7'd1;
            best_dist_reg <= npc_pkg::NO_MATCH_DIST;
            best_idx_reg  <= '0;
        end else begin
            if (rd_en) begin
                issue_idx_reg <= issue_idx_reg + 7'd1;
            end
            // Strictly smaller wins, so the lowest index survives a tie.
            if (dist_tag.valid && (dist_val < best_dist_reg)) begin
                best_dist_reg <= dist_val;
                best_idx_reg  <= dist_tag.index;
            end
        end

        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {3'b000, best_dist_reg, best_idx_reg, qtag_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
